FILE: hw/rtl/substring_search_whole_word_top_defines.svh
// assertion macros for the substring search block
`ifndef SUBSTRING_SEARCH_WHOLE_WORD_TOP_DEFINES_SVH
`define SUBSTRING_SEARCH_WHOLE_WORD_TOP_DEFINES_SVH

// same-cycle implication
`define SSW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssw assertion failed");

// next-cycle implication
`define SSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssw assertion failed");

`endif

FILE: hw/rtl/ssw_pkg.sv
package ssw_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CASE_INSENSITIVE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WHOLE_WORDS      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_START     = 3'd5;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CASE_DELTA      = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_block;
    } text_t;

    typedef struct packed {
        logic        found;
        logic [15:0] match_position;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [63:0]            value;
    } cfg_t;

    // control broadcast along the cell row
    typedef struct packed {
        logic [7:0] text_byte;
        logic       case_insensitive;
        logic       step;
        logic       clear;
    } cell_ctl_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic enable);
        logic [7:0] r;
        r = c;
        if (enable && c >= 8'h61 && c <= 8'h7a)
        begin
            r = c - CASE_DELTA;
        end
        return r;
    endfunction

    function automatic logic is_word_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
    endfunction

endpackage

FILE: hw/rtl/ssw_stream_if.sv
interface ssw_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ssw_cell.sv
module ssw_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  ssw_pkg::cell_ctl_t ctl,
    input  logic [7:0]        pattern_byte,
    input  logic              in_use,
    input  logic              prog_in,
    output logic              prog_out,
    output logic              prog_next
);

    logic prog_reg;
    logic eq;

    assign eq = ssw_pkg::fold(pattern_byte, ctl.case_insensitive) ==
                ssw_pkg::fold(ctl.text_byte, ctl.case_insensitive);
    assign prog_next = prog_in && eq && in_use;
    assign prog_out  = prog_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            prog_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            prog_reg <= prog_next;
        end
    end

endmodule

FILE: hw/rtl/ssw_chain.sv
module ssw_chain #(
    parameter int PATTERN_MAX = 16,
    parameter int LEN_W       = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssw_pkg::cell_ctl_t     ctl,
    input  logic [127:0]           pattern,
    input  logic [LEN_W-1:0]       len_eff,
    input  logic                   inject,
    output logic [PATTERN_MAX-1:0] prog_next
);

    logic [PATTERN_MAX-1:0] prog_q;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [7:0] pbyte;
        logic       pin;
        logic       use_k;

        if (k < ssw_pkg::PATTERN_BYTES)
        begin : g_pat
            assign pbyte = pattern[8*k +: 8];
        end
        else
        begin : g_zero
            assign pbyte = 8'h00;
        end

        if (k == 0)
        begin : g_head
            assign pin = inject;
        end
        else
        begin : g_link
            assign pin = prog_q[k-1];
        end

        assign use_k = (k < int'(len_eff));

        ssw_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .pattern_byte (pbyte),
            .in_use       (use_k),
            .prog_in      (pin),
            .prog_out     (prog_q[k]),
            .prog_next    (prog_next[k])
        );
    end

endmodule

FILE: hw/rtl/substring_search_whole_word_top.sv
// a result is registered and appears on the output in the cycle after the byte that decides it
// throughput: one text byte per cycle, the match cells update in parallel
// input stalls only while a finished result waits and the receiver holds off
// reset: rst_n clears search state and the output valid, registers take defaults
module substring_search_whole_word_top #(
    parameter int PATTERN_MAX = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    ssw_stream_if.sink   text,
    ssw_stream_if.source result,
    ssw_stream_if.sink   cfg
);

`include "substring_search_whole_word_top_defines.svh"

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [4:0]  pattern_length_reg;
    logic        case_insensitive_reg;
    logic        whole_words_reg;
    logic [15:0] search_start_reg;

    logic        prev_word_reg;
    logic        cand_reg;
    logic [15:0] cand_off_reg;
    logic [15:0] offset_reg;
    logic        given_reg;

    logic        res_valid_reg;
    logic        res_found_reg;
    logic [15:0] res_pos_reg;

    logic                   accept;
    logic [7:0]             in_byte;
    logic                   in_last;
    logic                   w;
    logic                   active;
    logic                   cand_emit;
    logic                   searching;
    logic                   hit;
    logic                   hit_emit;
    logic                   emit_found;
    logic                   emit;
    logic [15:0]            pos;
    logic [15:0]            out_pos;
    logic [LEN_W-1:0]       len_eff;
    logic [IDX_W-1:0]       len_idx;
    logic [PATTERN_MAX-1:0] prog_next;
    logic                   inject;
    ssw_pkg::cell_ctl_t     ctl;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg      <= '0;
            pattern_high_reg     <= '0;
            pattern_length_reg   <= 5'd1;
            case_insensitive_reg <= 1'b1;
            whole_words_reg      <= 1'b0;
            search_start_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                ssw_pkg::REG_PATTERN_LOW:      pattern_low_reg <= cfg.data.value;
                ssw_pkg::REG_PATTERN_HIGH:     pattern_high_reg <= cfg.data.value;
                ssw_pkg::REG_PATTERN_LENGTH:   pattern_length_reg <= cfg.data.value[4:0];
                ssw_pkg::REG_CASE_INSENSITIVE: case_insensitive_reg <= cfg.data.value[0];
                ssw_pkg::REG_WHOLE_WORDS:      whole_words_reg <= cfg.data.value[0];
                ssw_pkg::REG_SEARCH_START:     search_start_reg <= cfg.data.value[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // effective pattern length
    always_comb
    begin
        if (pattern_length_reg == 5'd0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (int'(pattern_length_reg) > PATTERN_MAX)
        begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = LEN_W'(pattern_length_reg);
        end
    end

    assign len_idx = IDX_W'(len_eff - LEN_W'(1));

    // input side
    assign text.ready = !res_valid_reg || result.ready;
    assign accept     = text.valid && text.ready;
    assign in_byte    = text.data.data_byte;
    assign in_last    = text.data.last_of_block;

    assign w          = ssw_pkg::is_word_byte(in_byte);
    assign active     = !given_reg;
    assign cand_emit  = active && cand_reg && !w;
    assign searching  = active && !cand_emit;
    assign hit        = searching && prog_next[len_idx];
    assign hit_emit   = hit && (!whole_words_reg || in_last);
    assign emit_found = cand_emit || hit_emit;
    assign emit       = accept && (emit_found || (in_last && active));
    assign inject     = !(whole_words_reg && prev_word_reg);

    assign pos = search_start_reg + offset_reg - 16'(len_eff - LEN_W'(1));

    always_comb
    begin
        if (cand_emit)
        begin
            out_pos = cand_off_reg;
        end
        else if (hit_emit)
        begin
            out_pos = pos;
        end
        else
        begin
            out_pos = '0;
        end
    end

    assign ctl.text_byte        = in_byte;
    assign ctl.case_insensitive = case_insensitive_reg;
    assign ctl.step             = accept && !in_last;
    assign ctl.clear            = accept && in_last;

    ssw_chain #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .pattern   ({pattern_high_reg, pattern_low_reg}),
        .len_eff   (len_eff),
        .inject    (inject),
        .prog_next (prog_next)
    );

    // block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_word_reg <= 1'b0;
            cand_reg      <= 1'b0;
            cand_off_reg  <= '0;
            offset_reg    <= '0;
            given_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                prev_word_reg <= 1'b0;
                cand_reg      <= 1'b0;
                cand_off_reg  <= '0;
                offset_reg    <= '0;
                given_reg     <= 1'b0;
            end
            else if (active)
            begin
                prev_word_reg <= w;
                offset_reg    <= offset_reg + 16'd1;
                given_reg     <= emit_found;
                cand_reg      <= hit && !hit_emit;
                if (hit && !hit_emit)
                begin
                    cand_off_reg <= pos;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_found_reg <= emit_found;
            res_pos_reg   <= out_pos;
        end
    end

    assign result.valid               = res_valid_reg;
    assign result.data.found          = res_found_reg;
    assign result.data.match_position = res_pos_reg;

    `SSW_ASSERT_NEXT(a_last_clears, accept && in_last, !given_reg && !cand_reg)
    `SSW_ASSERT_NOW(a_fail_zero_pos, res_valid_reg && !res_found_reg, res_pos_reg == 16'd0)
    `SSW_ASSERT_NOW(a_no_overrun, res_valid_reg && !result.ready, !text.ready)
    `SSW_ASSERT_NOW(a_cand_excl, cand_reg, !given_reg)

endmodule

FILE: tb/substring_search_whole_word_checker.sv
`timescale 1ns / 1ps

module substring_search_whole_word_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             text_valid,
    input  logic             text_ready,
    input  ssw_pkg::text_t   text_data,
    input  logic             result_valid,
    input  logic             result_ready,
    input  ssw_pkg::result_t result_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  ssw_pkg::cfg_t    cfg_data,
    output int               fail_count,
    output int               pending
);

    logic [63:0]                       pat_lo;
    logic [63:0]                       pat_hi;
    logic [4:0]                        pat_len;
    logic                              case_fold;
    logic                              word_mode;
    logic [15:0]                       start_pos;

    logic [ssw_pkg::PATTERN_BYTES-1:0] progress;
    logic                              prev_word;
    logic                              cand_pending;
    logic [15:0]                       cand_pos;
    logic [16:0]                       offset;
    logic                              done;

    ssw_pkg::result_t                  match_reports[$];

    function automatic logic [7:0] upcase(input logic [7:0] c, input logic en);
        logic [7:0] u;
        u = c;
        if (en && c >= "a" && c <= "z")
        begin
            u = c ^ 8'h20;
        end
        return u;
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || (c == "_");
    endfunction

    function automatic logic [7:0] pattern_char(input int k);
        logic [7:0] p;
        if (k < 8)
        begin
            p = pat_lo[8*k +: 8];
        end
        else
        begin
            p = pat_hi[8*(k-8) +: 8];
        end
        return p;
    endfunction

    task automatic clear_search();
        progress     = '0;
        prev_word    = 1'b0;
        cand_pending = 1'b0;
        cand_pos     = '0;
        offset       = '0;
        done         = 1'b0;
    endtask

    task automatic report(input logic found, input logic [15:0] pos);
        ssw_pkg::result_t r;
        r.found          = found;
        r.match_position = pos;
        match_reports.push_back(r);
    endtask

    task automatic write_register(input ssw_pkg::cfg_t c);
        case (c.index)
            ssw_pkg::REG_PATTERN_LOW:      pat_lo = c.value;
            ssw_pkg::REG_PATTERN_HIGH:     pat_hi = c.value;
            ssw_pkg::REG_PATTERN_LENGTH:   pat_len = c.value[4:0];
            ssw_pkg::REG_CASE_INSENSITIVE: case_fold = c.value[0];
            ssw_pkg::REG_WHOLE_WORDS:      word_mode = c.value[0];
            ssw_pkg::REG_SEARCH_START:     start_pos = c.value[15:0];
            default:                       ;
        endcase
    endtask

    task automatic scan_byte(input ssw_pkg::text_t t);
        int                                len;
        logic [ssw_pkg::PATTERN_BYTES-1:0] hits;
        logic [ssw_pkg::PATTERN_BYTES-1:0] mask;
        logic [7:0]                        folded;
        logic                              w;
        logic                              inject;
        logic [15:0]                       rel;
        len = pat_len;
        if (len < 1)
        begin
            len = 1;
        end
        if (len > ssw_pkg::PATTERN_BYTES)
        begin
            len = ssw_pkg::PATTERN_BYTES;
        end
        mask = {ssw_pkg::PATTERN_BYTES{1'b1}} >> (ssw_pkg::PATTERN_BYTES - len);
        if (done)
        begin
            if (t.last_of_block)
            begin
                clear_search();
            end
            return;
        end
        folded = upcase(t.data_byte, case_fold);
        w = word_char(t.data_byte);
        if (cand_pending)
        begin
            cand_pending = 1'b0;
            if (!w)
            begin
                report(1'b1, cand_pos);
                done = 1'b1;
            end
        end
        if (!done)
        begin
            hits = '0;
            for (int k = 0; k < len; k++)
            begin
                if (upcase(pattern_char(k), case_fold) == folded)
                begin
                    hits[k] = 1'b1;
                end
            end
            inject = !(word_mode && prev_word);
            progress = ((progress << 1) | ssw_pkg::PATTERN_BYTES'(inject)) & hits & mask;
            if (progress[len-1])
            begin
                rel = 16'(offset - 17'(len - 1));
                if (!word_mode || t.last_of_block)
                begin
                    report(1'b1, start_pos + rel);
                    done = 1'b1;
                end
                else
                begin
                    cand_pending = 1'b1;
                    cand_pos     = start_pos + rel;
                end
            end
        end
        prev_word = w;
        offset    = offset + 17'd1;
        if (t.last_of_block)
        begin
            if (!done)
            begin
                report(1'b0, 16'd0);
            end
            clear_search();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo     = '0;
            pat_hi     = '0;
            pat_len    = 5'd1;
            case_fold  = 1'b1;
            word_mode  = 1'b0;
            start_pos  = '0;
            clear_search();
            match_reports.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                write_register(cfg_data);
            end
            if (text_valid && text_ready)
            begin
                scan_byte(text_data);
            end
            if (result_valid && result_ready)
            begin
                if (match_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, actual found=%0b match_position=%0d",
                             $time, result_data.found, result_data.match_position);
                    fail_count++;
                end
                else if (match_reports[0].found !== result_data.found ||
                         match_reports[0].match_position !== result_data.match_position)
                begin
                    $display("%0t: expected found=%0b pos=%0d, actual found=%0b pos=%0d",
                             $time, match_reports[0].found, match_reports[0].match_position,
                             result_data.found, result_data.match_position);
                    fail_count++;
                    void'(match_reports.pop_front());
                end
                else
                begin
                    void'(match_reports.pop_front());
                end
            end
        end
        pending = match_reports.size();
    end

endmodule

FILE: tb/substring_search_whole_word_top_tb.sv
`timescale 1ns / 1ps

module substring_search_whole_word_top_tb;

    localparam int LONG_HOLD   = 80;
    localparam int SETTLE      = 4;
    localparam int LONG_BLOCK  = 40;
    localparam int PHASES      = 9;
    localparam int PHASE_BYTES = 45;
    localparam int BURST       = 30;

    localparam logic [ssw_pkg::CFG_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [ssw_pkg::CFG_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   calm;
    bit   hold_request;
    int   fail_count;
    int   pending;
    int   bytes_sent;

    logic [7:0] cur_pattern[ssw_pkg::PATTERN_BYTES];
    int         cur_len;
    logic       cur_ci;

    ssw_stream_if #(.T(ssw_pkg::text_t))   text_if();
    ssw_stream_if #(.T(ssw_pkg::result_t)) result_if();
    ssw_stream_if #(.T(ssw_pkg::cfg_t))    cfg_if();

    substring_search_whole_word_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    substring_search_whole_word_checker search_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_if.valid),
        .text_ready   (text_if.ready),
        .text_data    (text_if.data),
        .result_valid (result_if.valid),
        .result_ready (result_if.ready),
        .result_data  (result_if.data),
        .cfg_valid    (cfg_if.valid),
        .cfg_ready    (cfg_if.ready),
        .cfg_data     (cfg_if.data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2: c = 8'("a" + $urandom_range(0, 3));
            3, 4:    c = 8'("A" + $urandom_range(0, 3));
            5:       c = 8'("0" + $urandom_range(0, 9));
            6:       c = "_";
            7:       c = " ";
            8:       c = ".";
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic send_text(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.data  <= '{data_byte: b, last_of_block: last};
        @(posedge clk);
        while (!text_if.ready) @(posedge clk);
    endtask

    task automatic send_block(input logic [7:0] blk[$]);
        for (int i = 0; i < blk.size(); i++)
        begin
            send_text(blk[i], i == blk.size() - 1);
        end
        bytes_sent += blk.size();
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_text(s[i], i == s.len() - 1);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        text_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ssw_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, value: val};
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic ci, input logic ww,
                              input logic [15:0] ss);
        write_reg(ssw_pkg::REG_PATTERN_LOW, lo);
        write_reg(ssw_pkg::REG_PATTERN_HIGH, hi);
        write_reg(ssw_pkg::REG_PATTERN_LENGTH, 64'(len));
        write_reg(ssw_pkg::REG_CASE_INSENSITIVE, 64'(ci));
        write_reg(ssw_pkg::REG_WHOLE_WORDS, 64'(ww));
        write_reg(ssw_pkg::REG_SEARCH_START, 64'(ss));
    endtask

    task automatic set_pattern_str(input string s, input logic ci, input logic ww,
                                   input logic [15:0] ss);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = '0;
        hi = '0;
        for (int k = 0; k < s.len(); k++)
        begin
            if (k < 8)
            begin
                lo[8*k +: 8] = s[k];
            end
            else
            begin
                hi[8*(k-8) +: 8] = s[k];
            end
        end
        set_config(lo, hi, 5'(s.len()), ci, ww, ss);
    endtask

    task automatic send_random_block();
        logic [7:0] blk[$];
        logic [7:0] c;
        int         kind;
        int         cut;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            repeat ($urandom_range(0, 6)) blk.push_back(text_char());
            if ($urandom_range(0, 1))
            begin
                blk.push_back(" ");
            end
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cur_len) : cur_len;
            for (int k = 0; k < cut; k++)
            begin
                c = cur_pattern[k];
                if (cur_ci && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                    $urandom_range(0, 1))
                begin
                    c = c ^ 8'h20;
                end
                blk.push_back(c);
            end
            if ($urandom_range(0, 1))
            begin
                blk.push_back(" ");
            end
            repeat ($urandom_range(0, 6)) blk.push_back(text_char());
        end
        else if (kind < 9)
        begin
            repeat ($urandom_range(1, 12)) blk.push_back(text_char());
        end
        else
        begin
            repeat ($urandom_range(1, 8)) blk.push_back(8'($urandom_range(0, 255)));
        end
        send_block(blk);
    endtask

    // result side, with a long hold-off on request
    initial
    begin
        int rx_gap;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                rx_gap = pick_gap();
                if (rx_gap == 0)
                begin
                    result_if.ready <= 1'b1;
                end
                else
                begin
                    result_if.ready <= 1'b0;
                    repeat (rx_gap - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("substring_search_whole_word_top: mismatch");
        $finish;
    end

    initial
    begin
        logic [7:0]  blk[$];
        logic [63:0] lo;
        logic [63:0] hi;
        int          sel;
        int          raw_len;
        text_if.valid = 1'b0;
        text_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset pattern is a single zero byte
        blk = '{8'h41, 8'h00};
        send_block(blk);

        drain();
        set_pattern_str("ab", 1'b1, 1'b0, 16'd100);
        send_str("xABq");
        drain();
        set_pattern_str("ab", 1'b0, 1'b0, 16'd100);
        send_str("ABab");

        // whole words: bad start, candidate dropped, candidate taken, match on last byte
        drain();
        set_pattern_str("ab", 1'b1, 1'b1, 16'd0);
        send_str("cab abx ab.");
        send_str("zz ab");
        send_str("zzz");

        drain();
        set_config('1, '0, 5'd16, 1'b1, 1'b1, 16'hFFFF);
        blk.delete();
        repeat (8) blk.push_back(8'hFF);
        repeat (8) blk.push_back(8'h00);
        send_block(blk);

        // oversized length acts as full pattern, position wraps
        drain();
        write_reg(ssw_pkg::REG_PATTERN_LENGTH, 64'd31);
        write_reg(ssw_pkg::REG_WHOLE_WORDS, 64'd0);
        blk.push_front(" ");
        send_block(blk);

        // zero length acts as one, spare indexes are ignored
        drain();
        set_config(64'h5F, '1, 5'd0, 1'b0, 1'b1, 16'd7);
        write_reg(REG_SPARE_LOW, '1);
        write_reg(REG_SPARE_HIGH, '1);
        send_str("a_ _");

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            for (int k = 0; k < ssw_pkg::PATTERN_BYTES; k++)
            begin
                cur_pattern[k] = text_char();
            end
            for (int k = 0; k < 8; k++)
            begin
                lo[8*k +: 8] = cur_pattern[k];
                hi[8*k +: 8] = cur_pattern[k+8];
            end
            sel = $urandom_range(0, 19);
            if (sel == 0)
            begin
                raw_len = 0;
            end
            else if (sel == 1)
            begin
                raw_len = $urandom_range(17, 31);
            end
            else if (sel < 12)
            begin
                raw_len = $urandom_range(1, 4);
            end
            else
            begin
                raw_len = $urandom_range(5, 16);
            end
            cur_len = (raw_len == 0) ? 1 :
                      (raw_len > ssw_pkg::PATTERN_BYTES) ? ssw_pkg::PATTERN_BYTES : raw_len;
            cur_ci  = 1'($urandom_range(0, 1));
            set_config(lo, hi, 5'(raw_len), cur_ci, 1'($urandom_range(0, 1)),
                       (phase == 0) ? 16'd0 :
                       (phase == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
            calm = (phase == 4);
            if (phase == 3)
            begin
                hold_request = 1'b1;
                repeat (BURST) send_text(text_char(), 1'b1);
            end
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) send_random_block();
        end

        // match position wraps past the 16-bit range
        drain();
        set_pattern_str("WRAP", 1'b0, 1'b1, 16'd65500);
        calm = 1'b1;
        repeat (LONG_BLOCK) send_text("-", 1'b0);
        send_str("WRAP");
        drain();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("substring_search_whole_word_top: match");
        end
        else
        begin
            $display("substring_search_whole_word_top: mismatch");
        end
        $finish;
    end

endmodule
